@@ rtl/trp_pkg.sv @@
// Types, register indexes and coordinate mapping shared by the touch report processor.
package trp_pkg;

  localparam int unsigned STATUS_READY_BIT = 7;
  localparam logic [3:0]  CODE_RELEASED    = 4'd6;
  localparam logic [3:0]  CODE_CLEARED     = 4'd0;
  localparam logic [7:0]  STREAK_MAX       = 8'hFF;

  typedef enum logic [2:0] {
    REG_SWAP_AXES    = 3'd0,
    REG_MIRROR_X     = 3'd1,
    REG_MIRROR_Y     = 3'd2,
    REG_PANEL_WIDTH  = 3'd3,
    REG_PANEL_HEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        status_read_ok;
    logic [7:0]  status_byte;
    logic        point_read_ok;
    logic [7:0]  track_id;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic        report_written;
    logic [7:0]  report_code;
    logic [15:0] report_x;
    logic [15:0] report_y;
    logic        changed;
    logic        disabled_flag;
  } out_word_t;

  // mirror across the panel, then clamp to it; size 0 leaves the axis untouched
  function automatic logic [15:0] map_axis(input logic [15:0] v, input logic [15:0] size,
                                           input logic mirror);
    logic [15:0] r;
    r = v;
    if (mirror && (size != 16'd0)) begin
      r = (size > v) ? (size - 16'd1 - v) : 16'd0;
    end
    if ((size != 16'd0) && (r >= size)) begin
      r = size - 16'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/touch_report_processor_core.sv @@
// Touch report processor: failure tracking, point mapping and report packing.
//
// Each accepted word is handled in the cycle it is accepted: the status and point
// checks, the swap/mirror/clamp of the point and the compare against the last
// touch all sit between the input port and the result register, so one word is
// taken every clock while in_stall_o is low; its report goes into the result
// register, or into the skid register behind it while out_stall_i holds a report;
// in_stall_o rises only when both are full. Registers are on an APB-style port at
// byte addresses 0x00 (swap_axes), 0x04 (mirror_x), 0x08 (mirror_y),
// 0x0C (panel_width) and 0x10 (panel_height); write them only while idle.
module touch_report_processor_core #(
  parameter int unsigned FAIL_LIMIT   = 5,
  parameter int unsigned MAX_CONTACTS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  trp_pkg::in_word_t  in_word_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trp_pkg::out_word_t out_word_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CntW = $clog2(MAX_CONTACTS + 1);

  // configuration
  logic        swap_axes_q, mirror_x_q, mirror_y_q;
  logic [15:0] panel_width_q, panel_height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_axes_q    <= 1'b0;
      mirror_x_q     <= 1'b0;
      mirror_y_q     <= 1'b0;
      panel_width_q  <= 16'd0;
      panel_height_q <= 16'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        trp_pkg::REG_SWAP_AXES:    swap_axes_q    <= pwdata[0];
        trp_pkg::REG_MIRROR_X:     mirror_x_q     <= pwdata[0];
        trp_pkg::REG_MIRROR_Y:     mirror_y_q     <= pwdata[0];
        trp_pkg::REG_PANEL_WIDTH:  panel_width_q  <= pwdata[15:0];
        trp_pkg::REG_PANEL_HEIGHT: panel_height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      trp_pkg::REG_SWAP_AXES:    prdata = {31'd0, swap_axes_q};
      trp_pkg::REG_MIRROR_X:     prdata = {31'd0, mirror_x_q};
      trp_pkg::REG_MIRROR_Y:     prdata = {31'd0, mirror_y_q};
      trp_pkg::REG_PANEL_WIDTH:  prdata = {16'd0, panel_width_q};
      trp_pkg::REG_PANEL_HEIGHT: prdata = {16'd0, panel_height_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // touch state
  logic [15:0]     prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CntW-1:0] prev_count_q, prev_count_d;
  logic [7:0]      prev_id_q, prev_id_d;
  logic            touched_q, touched_d;
  logic [7:0]      streak_q, streak_d;
  logic            disabled_q, disabled_d;

  logic               accept;
  logic [3:0]         cnt;
  logic               cnt_zero, frame_ok, pt_fail, report;
  logic [7:0]         streak_inc;
  logic [15:0]        sw_x, sw_y, map_x, map_y, new_x, new_y;
  logic [7:0]         new_id;
  logic               chg;
  trp_pkg::out_word_t res;

  assign accept   = in_valid_i & ~in_stall_o;
  assign cnt      = in_word_i.status_byte[3:0];
  assign cnt_zero = (cnt == 4'd0);
  assign frame_ok = in_word_i.status_byte[trp_pkg::STATUS_READY_BIT] &
                    (cnt <= 4'(MAX_CONTACTS));
  assign pt_fail  = frame_ok & ~cnt_zero & ~in_word_i.point_read_ok;
  assign report   = ~disabled_q & in_word_i.status_read_ok & frame_ok & ~pt_fail;

  assign streak_inc = (streak_q == trp_pkg::STREAK_MAX) ? streak_q : streak_q + 8'd1;

  assign sw_x  = swap_axes_q ? in_word_i.raw_y : in_word_i.raw_x;
  assign sw_y  = swap_axes_q ? in_word_i.raw_x : in_word_i.raw_y;
  assign map_x = trp_pkg::map_axis(sw_x, panel_width_q, mirror_x_q);
  assign map_y = trp_pkg::map_axis(sw_y, panel_height_q, mirror_y_q);

  assign new_x  = cnt_zero ? prev_x_q  : map_x;
  assign new_y  = cnt_zero ? prev_y_q  : map_y;
  assign new_id = cnt_zero ? prev_id_q : in_word_i.track_id;

  assign chg = (cnt != 4'(prev_count_q)) ||
               (!cnt_zero && ((new_x != prev_x_q) || (new_y != prev_y_q) ||
                              (new_id != prev_id_q)));

  always_comb begin
    streak_d     = streak_q;
    disabled_d   = disabled_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    prev_count_d = prev_count_q;
    prev_id_d    = prev_id_q;
    touched_d    = touched_q;
    if (accept && !disabled_q) begin
      priority if (!in_word_i.status_read_ok) begin
        streak_d   = streak_inc;
        disabled_d = (streak_inc >= 8'(FAIL_LIMIT));
      end else if (pt_fail) begin
        streak_d   = 8'd1;
        disabled_d = (FAIL_LIMIT <= 1);
      end else begin
        streak_d = 8'd0;
      end
      if (report) begin
        prev_x_d     = new_x;
        prev_y_d     = new_y;
        prev_count_d = CntW'(cnt);
        prev_id_d    = new_id;
        touched_d    = touched_q | ~cnt_zero;
      end
    end
  end

  always_comb begin
    res = '0;
    res.disabled_flag = disabled_d;
    if (report) begin
      res.report_written = 1'b1;
      res.changed        = chg;
      if (cnt_zero && !touched_q) begin
        res.report_code = {4'd0, trp_pkg::CODE_CLEARED};
      end else begin
        res.report_code = {new_id[3:0], cnt_zero ? trp_pkg::CODE_RELEASED : cnt};
        res.report_x    = new_x;
        res.report_y    = new_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= 16'd0;
      prev_y_q     <= 16'd0;
      prev_count_q <= '0;
      prev_id_q    <= 8'd0;
      touched_q    <= 1'b0;
      streak_q     <= 8'd0;
      disabled_q   <= 1'b0;
    end else begin
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      prev_count_q <= prev_count_d;
      prev_id_q    <= prev_id_d;
      touched_q    <= touched_d;
      streak_q     <= streak_d;
      disabled_q   <= disabled_d;
    end
  end

  // result register with skid
  logic               out_valid_q, skid_valid_q;
  trp_pkg::out_word_t out_word_q, skid_word_q;
  logic               out_free;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (out_free) begin
        out_word_q <= res;
      end else begin
        skid_word_q <= res;
      end
    end else if (out_free && skid_valid_q) begin
      out_word_q <= skid_word_q;
    end
  end

endmodule

@@ rtl/trp_checker.sv @@
// Port-level checks for the touch report processor, bound to touch_report_processor_core.
module trp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input trp_pkg::out_word_t out_word_o
);

  // input backs up only when a report is already held
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("in_stall_o high with no report pending");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled report dropped");

  a_rose_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("report appeared without an accepted word");

  a_no_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!out_word_o.report_written || out_word_o.disabled_flag) |->
      out_word_o.report_code == 8'd0 && out_word_o.report_x == 16'd0 &&
      out_word_o.report_y == 16'd0 && !out_word_o.changed &&
      !out_word_o.report_written)
    else $error("report fields set without a report");

  a_cleared_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.report_written && out_word_o.report_code[3:0] == 4'd0 |->
      out_word_o.report_code[7:4] == 4'd0 && out_word_o.report_x == 16'd0 &&
      out_word_o.report_y == 16'd0)
    else $error("cleared report carries a point or id");

endmodule

bind touch_report_processor_core trp_checker u_trp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

@@ verif/trp_report_checker.sv @@
// Touch report checker: predicts each report from the accepted attempts and compares.
`timescale 1ns / 1ps

module trp_report_checker #(
  parameter int unsigned FAIL_LIMIT   = 5,
  parameter int unsigned MAX_CONTACTS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  trp_pkg::in_word_t  in_word_i,

  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  trp_pkg::out_word_t out_word_i,

  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [4:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,

  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  trp_pkg::out_word_t reports_due[$];
  int unsigned fail_count;
  int unsigned pending;

  logic        swap_cfg;
  logic        mirror_x_cfg;
  logic        mirror_y_cfg;
  logic [15:0] width_cfg;
  logic [15:0] height_cfg;

  logic [15:0] last_x;
  logic [15:0] last_y;
  logic [3:0]  prior_count;
  logic [7:0]  last_id;
  logic        seen_touch;
  logic [7:0]  fail_streak;
  logic        halted;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // size 0 passes the axis through; a mirrored point past the panel lands on 0
  function automatic logic [15:0] fold_axis(input logic [15:0] v, input logic [15:0] size,
                                            input logic mirror);
    if (size == 16'd0) begin
      return v;
    end
    if (mirror) begin
      return (v >= size) ? 16'd0 : size - 16'd1 - v;
    end
    return (v >= size) ? size - 16'd1 : v;
  endfunction

  function automatic void bump_streak();
    if (fail_streak != trp_pkg::STREAK_MAX) begin
      fail_streak = fail_streak + 8'd1;
    end
    if (fail_streak >= FAIL_LIMIT) begin
      halted = 1'b1;
    end
  endfunction

  function automatic trp_pkg::out_word_t predict_report(input trp_pkg::in_word_t w);
    trp_pkg::out_word_t r;
    logic [3:0]  n;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  id;
    logic        moved;
    r = '0;
    if (!halted) begin
      if (!w.status_read_ok) begin
        bump_streak();
      end else begin
        fail_streak = 8'd0;
        n = w.status_byte[3:0];
        if (w.status_byte[trp_pkg::STATUS_READY_BIT] && (n <= MAX_CONTACTS)) begin
          if ((n != 4'd0) && !w.point_read_ok) begin
            bump_streak();
          end else begin
            if (n != 4'd0) begin
              seen_touch = 1'b1;
              px = swap_cfg ? w.raw_y : w.raw_x;
              py = swap_cfg ? w.raw_x : w.raw_y;
              px = fold_axis(px, width_cfg, mirror_x_cfg);
              py = fold_axis(py, height_cfg, mirror_y_cfg);
              id = w.track_id;
            end else begin
              px = last_x;
              py = last_y;
              id = last_id;
            end
            moved = (n != prior_count) ||
                    ((n != 4'd0) && ((px != last_x) || (py != last_y) || (id != last_id)));
            prior_count = n;
            last_x      = px;
            last_y      = py;
            last_id     = id;
            r.report_written = 1'b1;
            r.changed        = moved;
            if ((n != 4'd0) || seen_touch) begin
              r.report_code = {id[3:0], (n == 4'd0) ? trp_pkg::CODE_RELEASED : n};
              r.report_x    = px;
              r.report_y    = py;
            end
          end
        end
      end
    end
    r.disabled_flag = halted;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trp_pkg::out_word_t want;
    if (!rst_ni) begin
      reports_due.delete();
      fail_count   = 0;
      pending      = 0;
      swap_cfg     = 1'b0;
      mirror_x_cfg = 1'b0;
      mirror_y_cfg = 1'b0;
      width_cfg    = 16'd0;
      height_cfg   = 16'd0;
      last_x       = 16'd0;
      last_y       = 16'd0;
      prior_count  = 4'd0;
      last_id      = 8'd0;
      seen_touch   = 1'b0;
      fail_streak  = 8'd0;
      halted       = 1'b0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          trp_pkg::REG_SWAP_AXES:    swap_cfg     = pwdata_i[0];
          trp_pkg::REG_MIRROR_X:     mirror_x_cfg = pwdata_i[0];
          trp_pkg::REG_MIRROR_Y:     mirror_y_cfg = pwdata_i[0];
          trp_pkg::REG_PANEL_WIDTH:  width_cfg    = pwdata_i[15:0];
          trp_pkg::REG_PANEL_HEIGHT: height_cfg   = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (reports_due.size() == 0) begin
          $error("report word 0x%0h arrived with none pending", out_word_i);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("report_written", 16'(want.report_written),
                      16'(out_word_i.report_written));
          check_field("report_code", 16'(want.report_code), 16'(out_word_i.report_code));
          check_field("report_x", want.report_x, out_word_i.report_x);
          check_field("report_y", want.report_y, out_word_i.report_y);
          check_field("changed", 16'(want.changed), 16'(out_word_i.changed));
          check_field("disabled_flag", 16'(want.disabled_flag),
                      16'(out_word_i.disabled_flag));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        reports_due.push_back(predict_report(in_word_i));
      end
      pending = reports_due.size();
    end
  end

endmodule

@@ verif/touch_report_processor_core_test.sv @@
// Top of the touch report processor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module touch_report_processor_core_test;

  localparam int unsigned FAIL_LIMIT     = 5;
  localparam int unsigned MAX_CONTACTS   = 5;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  trp_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  trp_pkg::out_word_t out_word_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [4:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned fail_count;
  int unsigned pending;

  logic        sender_idles = 1'b1;
  logic        recv_idles   = 1'b1;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_run     = 0;
  logic [15:0] cur_w        = 16'd0;
  logic [15:0] cur_h        = 16'd0;

  touch_report_processor_core #(
    .FAIL_LIMIT  (FAIL_LIMIT),
    .MAX_CONTACTS(MAX_CONTACTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  trp_report_checker #(
    .FAIL_LIMIT  (FAIL_LIMIT),
    .MAX_CONTACTS(MAX_CONTACTS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, plus long hold-offs on request, counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_idles && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic trp_pkg::in_word_t attempt(input logic st_ok, input logic [7:0] st,
                                                input logic pt_ok, input logic [7:0] id,
                                                input logic [15:0] x, input logic [15:0] y);
    trp_pkg::in_word_t w;
    w.status_read_ok = st_ok;
    w.status_byte    = st;
    w.point_read_ok  = pt_ok;
    w.track_id       = id;
    w.raw_x          = x;
    w.raw_y          = y;
    return w;
  endfunction

  // partly around the panel rim, where mirror and clamp turn over, partly random or at the extremes
  function automatic logic [15:0] pick_coord();
    logic [15:0] rim;
    rim = $urandom_range(0, 1) ? cur_w : cur_h;
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 1023));
      2:       return rim + 16'($urandom_range(0, 4)) - 16'd2;
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic send_attempt(input trp_pkg::in_word_t w);
    while (sender_idles && ($urandom_range(0, 99) < 8)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (!w.status_read_ok) begin
      fail_run++;
    end else if (w.status_byte[trp_pkg::STATUS_READY_BIT] && (w.status_byte[3:0] != 4'd0) &&
                 (w.status_byte[3:0] <= MAX_CONTACTS) && !w.point_read_ok) begin
      fail_run = 1;
    end else begin
      fail_run = 0;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(input trp_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_panel(input logic swap, input logic mx, input logic my,
                           input logic [15:0] w, input logic [15:0] h);
    apb_write(trp_pkg::REG_SWAP_AXES, {31'd0, swap});
    apb_write(trp_pkg::REG_MIRROR_X, {31'd0, mx});
    apb_write(trp_pkg::REG_MIRROR_Y, {31'd0, my});
    apb_write(trp_pkg::REG_PANEL_WIDTH, {16'd0, w});
    apb_write(trp_pkg::REG_PANEL_HEIGHT, {16'd0, h});
    cur_w = w;
    cur_h = h;
  endtask

  initial begin
    trp_pkg::in_word_t w;
    trp_pkg::in_word_t last_sent;
    int unsigned phase;
    int unsigned k;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_panel(1'b1, 1'b1, 1'b1, 16'd800, 16'd480);
    // release before any touch, then every way an attempt can be dropped
    send_attempt(attempt(1'b1, 8'h80, 1'b1, 8'h3C, 16'd10, 16'd20));
    send_attempt(attempt(1'b1, 8'h05, 1'b1, 8'h11, 16'd1, 16'd2));
    send_attempt(attempt(1'b1, 8'h8F, 1'b1, 8'h12, 16'd3, 16'd4));
    send_attempt(attempt(1'b1, 8'h86, 1'b1, 8'h13, 16'd5, 16'd6));
    send_attempt(attempt(1'b0, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_attempt(attempt(1'b1, 8'h81, 1'b0, 8'h14, 16'd7, 16'd8));
    // touches at the extremes, a repeat, and the panel edges
    send_attempt(attempt(1'b1, 8'h81, 1'b1, 8'hFF, 16'h0000, 16'h0000));
    send_attempt(attempt(1'b1, 8'h81, 1'b1, 8'hFF, 16'h0000, 16'h0000));
    send_attempt(attempt(1'b1, 8'hF5, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF));
    send_attempt(attempt(1'b1, 8'h82, 1'b1, 8'h5A, 16'd479, 16'd799));
    send_attempt(attempt(1'b1, 8'h83, 1'b1, 8'hA5, 16'd480, 16'd800));
    send_attempt(attempt(1'b1, 8'h84, 1'b1, 8'hA5, 16'd480, 16'd800));
    // release with a failed point read and junk point, then again, then two dropped frames
    send_attempt(attempt(1'b1, 8'h80, 1'b0, 8'hC3, 16'h1234, 16'h5678));
    send_attempt(attempt(1'b1, 8'hF0, 1'b1, 8'h77, 16'd9, 16'd9));
    send_attempt(attempt(1'b1, 8'hFF, 1'b1, 8'h77, 16'd9, 16'd9));
    send_attempt(attempt(1'b1, 8'h7F, 1'b0, 8'h77, 16'd9, 16'd9));
    drain();

    last_sent = '0;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_panel(1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
        1:       set_panel(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        2:       set_panel(1'b0, 1'b1, 1'b0, 16'd1, 16'd1);
        3:       set_panel(1'b1, 1'b0, 1'b1, 16'd320, 16'd240);
        4:       set_panel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)),
                           16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)));
        default: set_panel(1'b1, 1'b1, 1'b0, 16'hFFFF, 16'd0);
      endcase
      sender_idles = (phase != 2);
      recv_idles   = (phase != 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ((phase == 3) && (k == 40)) begin
          holds_asked++;
        end
        w = last_sent;
        if ($urandom_range(0, 3) != 0) begin
          w.track_id = 8'($urandom);
          w.raw_x    = pick_coord();
          w.raw_y    = pick_coord();
        end
        // keep the failure streak short of the limit until the closing part
        w.status_read_ok = ($urandom_range(0, 99) >= 8) || (fail_run + 1 >= FAIL_LIMIT);
        case ($urandom_range(0, 19))
          0, 1:    w.status_byte = {1'b0, 7'($urandom)};
          2, 3:    w.status_byte = {1'b1, 3'($urandom),
                                    4'($urandom_range(MAX_CONTACTS + 1, 15))};
          4, 5, 6: w.status_byte = {1'b1, 3'($urandom), 4'd0};
          default: w.status_byte = {1'b1, 3'($urandom), 4'($urandom_range(1, MAX_CONTACTS))};
        endcase
        w.point_read_ok = ($urandom_range(0, 99) >= 6);
        send_attempt(w);
        last_sent = w;
      end
      drain();
    end

    // point failure starts the streak, status failures finish it; then all is ignored
    sender_idles = 1'b1;
    recv_idles   = 1'b1;
    send_attempt(attempt(1'b1, 8'h83, 1'b0, 8'h21, 16'd50, 16'd60));
    for (k = 0; k < FAIL_LIMIT - 1; k++) begin
      send_attempt(attempt(1'b0, 8'($urandom), 1'b1, 8'($urandom), 16'd1, 16'd1));
    end
    send_attempt(attempt(1'b1, 8'h82, 1'b1, 8'h42, 16'd100, 16'd200));
    send_attempt(attempt(1'b1, 8'h80, 1'b1, 8'h42, 16'd100, 16'd200));
    send_attempt(attempt(1'b0, 8'h81, 1'b1, 8'h42, 16'd100, 16'd200));
    send_attempt(attempt(1'b1, 8'h01, 1'b1, 8'h42, 16'd100, 16'd200));
    drain();
    repeat (8) @(posedge clk_i);

    if ((fail_count == 0) && (pending == 0)) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
